// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
// no dependencies; assertions vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define CTH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define CTH_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define CTH_ASSERT(lbl, clk, rst, prop)
`define CTH_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== design/cths_pkg.sv =====
// constants, table type and build-time crypt table for the string hash
// no dependencies
package cths_pkg;

   localparam int HashTypes  = 5;
   localparam int TableWords = HashTypes * 256;
   localparam int TypeBits   = (HashTypes > 1) ? $clog2(HashTypes) : 1;
   localparam int AddrBits   = $clog2(TableWords);

   localparam logic [31:0] SeedOneStart = 32'h7FED_7FED;
   localparam logic [31:0] SeedTwoStart = 32'hEEEE_EEEE;
   localparam logic [31:0] GenStart     = 32'h0010_0001;
   localparam logic [31:0] GenMul       = 32'd125;
   localparam logic [31:0] GenMod       = 32'h002A_AAAB;
   localparam logic [31:0] HalfMask     = 32'h0000_FFFF;

   typedef logic [31:0] crypt_table_type [TableWords];

   // one step of the congruential generator, value stays below GenMod
   function automatic logic [31:0] gen_next(input logic [31:0] g);
      return (g * GenMul + 32'd3) % GenMod;
   endfunction

   // evaluated at elaboration only
   function automatic crypt_table_type build_table();
      crypt_table_type tbl;
      logic [31:0]     g;
      logic [31:0]     hi_word;
      g = GenStart;
      for (int b = 0; b < 256; b++) begin
         for (int t = 0; t < HashTypes; t++) begin
            g       = gen_next(g);
            hi_word = g & HalfMask;
            g       = gen_next(g);
            tbl[t * 256 + b] = {hi_word[15:0], g[15:0]};
         end
      end
      return tbl;
   endfunction

   localparam crypt_table_type CryptTable = build_table();

endpackage

// ===== design/crypt_table_string_hash.sv =====
// string hash top level: rom lookup stage, seed mixing stage, output register
// depends on cths_pkg and assert_macros.svh
//
// usage
//  - req channel carries one byte of a string per item plus the hash type
//    (table section); a zero byte ends the string
//  - rsp channel carries one finished 32-bit hash per string, produced by the
//    zero byte; nonzero bytes produce no item
//  - hash types at or above the section count fall back to the last section
// timing
//  - one item per cycle unless stalled; the crypt table is a build-time rom
//    with a registered read port, read once per item in the accept cycle
//  - hash appears on rsp after the zero byte passes the stage 1 register
//    and fires at the seed stage, which loads the output register
// reset
//  - synchronous, active high; empties the pipe and the output register and
//    loads both mixing seeds with their start values; no fill pass needed
// stalls
//  - the output register holds one hash; a second string end reaching the
//    seed stage while it is still held stalls that stage and drops req_ready
//  - otherwise req_ready stays high while rsp waits
`include "assert_macros.svh"

module crypt_table_string_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic [2:0]  req_hash_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   // stage 1: rom word and byte
   logic                         s1_valid_ff;
   logic                         s1_end_ff;
   logic [7:0]                   s1_byte_ff;
   logic [31:0]                  rom_word_ff;

   // mixing seeds
   logic [31:0]                  seed_one_ff;
   logic [31:0]                  seed_two_ff;
   logic [31:0]                  seed_one_in;
   logic [31:0]                  seed_two_in;

   // output register
   logic                         rsp_valid_ff;
   logic [31:0]                  rsp_hash_ff;

   logic                         req_accept;
   logic                         s1_stall;
   logic                         s1_fire;
   logic                         end_fire;
   logic [cths_pkg::TypeBits-1:0] type_sel;
   logic [cths_pkg::AddrBits-1:0] rom_addr;
   logic [31:0]                  seed_sum;

   // stall only when a string end meets a full output register
   assign s1_stall   = s1_valid_ff && s1_end_ff && rsp_valid_ff && !rsp_ready;
   assign req_ready  = !s1_stall;
   assign req_accept = req_valid && req_ready;
   assign s1_fire    = s1_valid_ff && !s1_stall;
   assign end_fire   = s1_fire && s1_end_ff;

   // clamp out-of-range hash type to the last section
   always_comb begin
      if (5'(req_hash_type) >= 5'(cths_pkg::HashTypes)) begin
         type_sel = cths_pkg::TypeBits'(cths_pkg::HashTypes - 1);
      end else begin
         type_sel = cths_pkg::TypeBits'(req_hash_type);
      end
      rom_addr = cths_pkg::AddrBits'({type_sel, req_char_byte});
   end

   // rom read and stage 1 payload, captured on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rom_word_ff <= cths_pkg::CryptTable[rom_addr];
         s1_byte_ff  <= req_char_byte;
         s1_end_ff   <= (req_char_byte == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_stall) begin
         s1_valid_ff <= req_accept;
      end
   end

   // seed mixing for a nonzero byte
   always_comb begin
      seed_sum    = seed_one_ff + seed_two_ff;
      seed_one_in = rom_word_ff ^ seed_sum;
      seed_two_in = 32'(s1_byte_ff) + seed_one_in + seed_two_ff
                    + (seed_two_ff << 5) + 32'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_one_ff <= cths_pkg::SeedOneStart;
         seed_two_ff <= cths_pkg::SeedTwoStart;
      end else if (s1_fire) begin
         if (s1_end_ff) begin
            // string done, restart seeds
            seed_one_ff <= cths_pkg::SeedOneStart;
            seed_two_ff <= cths_pkg::SeedTwoStart;
         end else begin
            seed_one_ff <= seed_one_in;
            seed_two_ff <= seed_two_in;
         end
      end
   end

   // output register, loaded with the finished first seed
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (end_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         rsp_hash_ff <= seed_one_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // seeds restart after every string end
   `CTH_ASSERT(a_seed_restart, clock, reset,
      end_fire |=> (seed_one_ff == cths_pkg::SeedOneStart &&
                    seed_two_ff == cths_pkg::SeedTwoStart))

   // a string end presents the seed it saw
   `CTH_ASSERT(a_hash_loaded, clock, reset,
      end_fire |=> (rsp_valid_ff && rsp_hash_ff == $past(seed_one_ff)))

   // an accepted item always reaches stage 1
   `CTH_ASSERT(a_accept_moves, clock, reset, req_accept |=> s1_valid_ff)

   // backpressure only from a held hash and a waiting string end
   `CTH_ASSERT_NEVER(a_ready_low, clock, reset,
      !req_ready && !(s1_valid_ff && s1_end_ff && rsp_valid_ff))

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for crypt_table_string_hash: directed strings, then random strings
// depends on cths_pkg for the section count and seed start values; drives only the ports

module testbench;

   localparam int          CycleLimit  = 300000;
   localparam int          RandomItems = 800;
   localparam int          DrainCycles = 8;
   localparam logic [31:0] LcgStart    = 32'h0010_0001;
   localparam int unsigned LcgMul      = 125;
   localparam int unsigned LcgMod      = 32'h002A_AAAB;

   // one row of the directed strings; fixed marks a hash typed in by hand
   typedef struct packed {
      logic [7:0]  ch;
      logic [2:0]  kind;
      logic        fixed;
      logic [31:0] hash;
   } dir_row_type;

   localparam int DirCount = 21;
   localparam dir_row_type DirRows [DirCount] = '{
      '{8'h00, 3'd0, 1'b1, cths_pkg::SeedOneStart},  // empty string straight out of reset
      '{8'h00, 3'd7, 1'b1, cths_pkg::SeedOneStart},  // empty string, end byte type ignored
      '{8'h61, 3'd0, 1'b0, 32'h0},         // lower-case letter
      '{8'h00, 3'd0, 1'b0, 32'h0},
      '{8'h41, 3'd0, 1'b0, 32'h0},         // upper-case letter, no folding
      '{8'h00, 3'd3, 1'b0, 32'h0},
      '{8'hFF, 3'd4, 1'b0, 32'h0},         // top byte, last section
      '{8'h01, 3'd4, 1'b0, 32'h0},         // lowest nonzero byte
      '{8'h00, 3'd4, 1'b0, 32'h0},
      '{8'hFF, 3'd7, 1'b0, 32'h0},         // type beyond the table clamps
      '{8'h00, 3'd5, 1'b0, 32'h0},
      '{8'h01, 3'd5, 1'b0, 32'h0},         // type changes inside one string
      '{8'h80, 3'd6, 1'b0, 32'h0},
      '{8'h7F, 3'd0, 1'b0, 32'h0},
      '{8'h00, 3'd2, 1'b0, 32'h0},
      '{8'h00, 3'd1, 1'b1, cths_pkg::SeedOneStart},  // seeds reloaded after a string
      '{8'h55, 3'd1, 1'b0, 32'h0},
      '{8'hAA, 3'd2, 1'b0, 32'h0},
      '{8'h00, 3'd7, 1'b0, 32'h0},
      '{8'h01, 3'd3, 1'b0, 32'h0},
      '{8'h00, 3'd0, 1'b0, 32'h0}
   };

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte  = 8'h00;
   logic [2:0]  req_hash_type  = 3'd0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_hash_value;

   // predictor state: own copy of the crypt table and both mixing seeds
   logic [31:0] crypt_rom [cths_pkg::HashTypes * 256];
   logic [31:0] seed_one;
   logic [31:0] seed_two;

   logic [31:0] pending_hashes [$];   // hashes still owed on rsp, oldest first
   logic [31:0] want_hash;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          items_sent     = 0;
   bit          calm           = 1'b0;   // no idling on either side while set

   crypt_table_string_hash u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_byte  (req_char_byte),
      .req_hash_type  (req_hash_type),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   always #5 clock = ~clock;

   // run limit, far above the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // fill the table from the congruential generator, two steps per word
   function automatic void load_crypt_rom();
      int unsigned lcg;
      logic [15:0] upper;
      lcg = LcgStart;
      for (int b = 0; b < 256; b++) begin
         for (int t = 0; t < cths_pkg::HashTypes; t++) begin
            lcg   = (lcg * LcgMul + 3) % LcgMod;
            upper = lcg[15:0];
            lcg   = (lcg * LcgMul + 3) % LcgMod;
            crypt_rom[t * 256 + b] = {upper, lcg[15:0]};
         end
      end
   endfunction

   // advance the seeds by one byte; returns 1 with the hash when the byte ends a string
   function automatic bit mix_char(input logic [7:0] c, input logic [2:0] t,
                                   output logic [31:0] hash);
      int unsigned section;
      logic [31:0] word;
      hash = seed_one;
      if (c == 8'h00) begin
         seed_one = cths_pkg::SeedOneStart;
         seed_two = cths_pkg::SeedTwoStart;
         return 1'b1;
      end
      section  = (t >= cths_pkg::HashTypes) ? cths_pkg::HashTypes - 1 : t;
      word     = crypt_rom[section * 256 + c];
      seed_one = word ^ (seed_one + seed_two);
      seed_two = {24'h0, c} + seed_one + seed_two + (seed_two << 5) + 32'd3;
      return 1'b0;
   endfunction

   // offer one item, idling first at random; called at a rising edge,
   // returns at the edge where the item is taken
   task automatic send_byte(input logic [7:0] c, input logic [2:0] t,
                            input bit has_fixed, input logic [31:0] fixed_hash);
      logic [31:0] hash;
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      req_hash_type <= t;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (mix_char(c, t, hash))
         pending_hashes.push_back(has_fixed ? fixed_hash : hash);
   endtask

   // hold the sender off until every owed hash has come back
   task automatic drain_hashes();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_hashes.size() != 0);
   endtask

   // receiver: check each taken hash against the oldest one owed, then pick ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_hashes.size() == 0) begin
               mismatch_count++;
               $display("%0t: hash expected none, actual %h", $time, rsp_hash_value);
            end else begin
               want_hash = pending_hashes.pop_front();
               if (rsp_hash_value !== want_hash) begin
                  mismatch_count++;
                  $display("%0t: hash expected %h, actual %h", $time, want_hash,
                           rsp_hash_value);
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
      end
   end

   // random string: mostly short, some empty, a few long; type mostly inside the table
   task automatic send_random_string();
      int          len;
      int          pick;
      logic [2:0]  kind;
      logic [7:0]  ch;
      pick = $urandom_range(0, 99);
      if (pick < 8)       len = 0;
      else if (pick < 93) len = $urandom_range(1, 12);
      else                len = $urandom_range(30, 64);
      kind = ($urandom_range(0, 99) < 80)
             ? 3'($urandom_range(0, cths_pkg::HashTypes - 1))
             : 3'($urandom_range(0, 7));
      for (int i = 0; i < len; i++) begin
         // now and then the type moves inside the string
         if ($urandom_range(0, 99) < 10)
            kind = 3'($urandom_range(0, 7));
         ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126))
                                          : 8'($urandom_range(1, 255));
         send_byte(ch, kind, 1'b0, 32'h0);
      end
      // the end byte carries any type, which must not matter
      send_byte(8'h00, 3'($urandom_range(0, 7)), 1'b0, 32'h0);
   endtask

   initial begin
      bit drained_mid;
      drained_mid = 1'b0;
      load_crypt_rom();
      seed_one = cths_pkg::SeedOneStart;
      seed_two = cths_pkg::SeedTwoStart;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings
      for (int i = 0; i < DirCount; i++)
         send_byte(DirRows[i].ch, DirRows[i].kind, DirRows[i].fixed, DirRows[i].hash);
      drain_hashes();

      // random strings, with a stretch of full rate on both sides in the middle
      items_sent = 0;
      while (items_sent < RandomItems) begin
         calm = (items_sent >= 300 && items_sent < 450);
         if (!drained_mid && items_sent >= 500) begin
            drain_hashes();
            drained_mid = 1'b1;
         end
         send_random_string();
      end
      calm = 1'b0;

      drain_hashes();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_hashes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/cths_pkg.sv
design/crypt_table_string_hash.sv
dv/testbench.sv
